[sv/gssp_pkg.sv]
// ----------------------------------------------------------------------------
// gssp_pkg: shared types and constants for the gear shift phase sequencer
// Field widths, phase and register codes, the state record and the Q1.8
// fraction helper that gssp_step uses.
// ----------------------------------------------------------------------------
package gssp_pkg;

  localparam int GearW    = 5;
  localparam int TopW     = 4;
  localparam int TimeW    = 16;
  localparam int TimerW   = 17;
  localparam int FracW    = 9;
  localparam int PhaseW   = 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // s_tdata: demanded_gear, elapsed -> 21 bits, padded to 24
  localparam int InDataW  = ((GearW + TimeW + 7) / 8) * 8;
  // m_tdata: gear_in_mesh, target, phase -> 12 bits, padded to 16
  localparam int OutBits  = GearW + GearW + PhaseW;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  // Shift phases
  localparam logic [PhaseW-1:0] PH_ENGAGED     = 2'd0;
  localparam logic [PhaseW-1:0] PH_DISENGAGING = 2'd1;
  localparam logic [PhaseW-1:0] PH_NEUTRAL     = 2'd2;
  localparam logic [PhaseW-1:0] PH_ENGAGING    = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TOP_GEAR      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UPSHIFT_TIME  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DOWNSHIFT_TIME = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DISENGAGE_FRAC = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ENGAGE_FRAC    = 3'd4;

  // Configuration reset values
  localparam logic [TopW-1:0]  TOP_GEAR_RST  = 4'd6;
  localparam logic [TimeW-1:0] UP_TIME_RST   = 16'd200;
  localparam logic [TimeW-1:0] DOWN_TIME_RST = 16'd250;
  localparam logic [FracW-1:0] DIS_FRAC_RST  = 9'd64;
  localparam logic [FracW-1:0] ENG_FRAC_RST  = 9'd64;

  localparam logic [FracW-1:0]  FRAC_ONE  = 9'd256;
  localparam logic [TimerW-1:0] TIMER_MAX = '1;

  typedef logic signed [GearW-1:0] gear_t;

  typedef struct packed {
    gear_t              current_gear;
    gear_t              target_gear;
    gear_t              from_gear;
    logic [PhaseW-1:0]  shift_phase;
    logic [TimerW-1:0]  shift_timer;
  } state_t;

  typedef struct packed {
    logic [TopW-1:0]  top_gear;
    logic [TimeW-1:0] upshift_time;
    logic [TimeW-1:0] downshift_time;
    logic [FracW-1:0] disengage_fraction;
    logic [FracW-1:0] engage_fraction;
  } cfg_t;

  // Both gears forward and different: the change goes through a timed shift.
  function automatic logic needs_timing(gear_t a, gear_t b);
    return (a > gear_t'(0)) && (b > gear_t'(0)) && (a != b);
  endfunction

  // floor(total * frac / 256), frac saturated at one
  function automatic logic [TimeW-1:0] frac_of(logic [TimeW-1:0] total,
                                                logic [FracW-1:0] frac);
    logic [FracW-1:0]         f;
    logic [TimeW+FracW-1:0]   prod;
    f    = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    prod = {{FracW{1'b0}}, total} * {{TimeW{1'b0}}, f};
    return prod[TimeW+7:8];
  endfunction

endpackage

[sv/gssp_step.sv]
// ----------------------------------------------------------------------------
// gssp_step: next-state logic for one tick
// Clamps the demand, then either applies an engaged-box change or advances
// the running shift timer through its phase boundaries.
// ----------------------------------------------------------------------------
module gssp_step (
  input  gssp_pkg::state_t                 cur_state,
  input  gssp_pkg::cfg_t                   cfg,
  input  gssp_pkg::gear_t                  demand,
  input  logic [gssp_pkg::TimeW-1:0]       elapsed,
  output gssp_pkg::state_t                 next_state
);

  gssp_pkg::gear_t                 want;
  gssp_pkg::gear_t                 top;
  gssp_pkg::gear_t                 tgt_new;
  logic [gssp_pkg::TimerW:0]       timer_sum;
  logic [gssp_pkg::TimerW-1:0]     timer_sat;
  logic [gssp_pkg::TimeW-1:0]      total;
  logic [gssp_pkg::TimeW-1:0]      opened;
  logic [gssp_pkg::TimeW-1:0]      engage_len;
  logic [gssp_pkg::TimeW-1:0]      closing_raw;
  logic [gssp_pkg::TimeW-1:0]      closing;

  // demand clamped to reverse .. top_gear
  always_comb begin
    top  = gssp_pkg::gear_t'({1'b0, cfg.top_gear});
    want = demand;
    if (want < -gssp_pkg::gear_t'(1)) begin
      want = -gssp_pkg::gear_t'(1);
    end
    if (want > top) begin
      want = top;
    end
  end

  // shift timing
  always_comb begin
    timer_sum   = {1'b0, cur_state.shift_timer} + {2'b00, elapsed};
    timer_sat   = timer_sum[gssp_pkg::TimerW] ? gssp_pkg::TIMER_MAX
                                               : timer_sum[gssp_pkg::TimerW-1:0];
    total       = (cur_state.target_gear > cur_state.from_gear) ? cfg.upshift_time
                                                                : cfg.downshift_time;
    opened      = gssp_pkg::frac_of(total, cfg.disengage_fraction);
    engage_len  = gssp_pkg::frac_of(total, cfg.engage_fraction);
    closing_raw = total - engage_len;
    closing     = (closing_raw < opened) ? opened : closing_raw;
  end

  always_comb begin
    next_state = cur_state;
    tgt_new    = cur_state.target_gear;
    if (cur_state.shift_phase == gssp_pkg::PH_ENGAGED) begin
      if (want != cur_state.current_gear) begin
        if (!gssp_pkg::needs_timing(cur_state.current_gear, want)) begin
          next_state.current_gear = want;
          next_state.target_gear  = want;
          next_state.from_gear    = want;
        end else begin
          next_state.from_gear   = cur_state.current_gear;
          next_state.target_gear = want;
          next_state.shift_phase = gssp_pkg::PH_DISENGAGING;
          next_state.shift_timer = '0;
        end
      end
    end else begin
      next_state.shift_timer = timer_sat;
      if (timer_sat >= {1'b0, total}) begin
        next_state.current_gear = cur_state.target_gear;
        next_state.from_gear    = cur_state.target_gear;
        next_state.shift_phase  = gssp_pkg::PH_ENGAGED;
        next_state.shift_timer  = '0;
      end else if (timer_sat >= {1'b0, closing}) begin
        next_state.shift_phase  = gssp_pkg::PH_ENGAGING;
        next_state.current_gear = cur_state.target_gear;
      end else if (timer_sat >= {1'b0, opened}) begin
        // neutral window: target may still move to another forward gear
        next_state.shift_phase = gssp_pkg::PH_NEUTRAL;
        if ((want != cur_state.target_gear) &&
            gssp_pkg::needs_timing(cur_state.from_gear, want)) begin
          tgt_new = want;
        end
        next_state.target_gear  = tgt_new;
        next_state.current_gear = tgt_new;
      end else begin
        next_state.shift_phase = gssp_pkg::PH_DISENGAGING;
      end
    end
  end

endmodule

[sv/gssp_obuf.sv]
// ----------------------------------------------------------------------------
// gssp_obuf: two-entry output buffer
// Output register plus a skid register, so a word can be taken in while the
// previous result still waits downstream.
// ----------------------------------------------------------------------------
module gssp_obuf #(
  parameter int DataW = gssp_pkg::OutDataW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [DataW-1:0] push_data,
  output logic             room,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [DataW-1:0] m_tdata
);

  logic             skid_valid;
  logic [DataW-1:0] skid_data;
  logic             out_free;

  assign room     = !skid_valid;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        // push cannot happen here: room is low while the skid is full
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : push_data;
    end
    if (push && !out_free) begin
      skid_data <= push_data;
    end
  end

endmodule

[sv/gear_shift_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// gear_shift_phase_sequencer: gearbox shift phase sequencer
// One tick word in (demanded gear, elapsed time), one result word out
// (gear in mesh, target gear, shift phase).
// ----------------------------------------------------------------------------
// Each accepted tick word updates the sequencer state in the same cycle and
// produces exactly one registered result word. A new tick word can be
// accepted every cycle while s_tready is high; the state update (clamp, two
// 16x9 boundary products, compares) is a single combinational step between
// the state registers, and a two-entry output buffer keeps the input side
// flowing while one result waits downstream. s_tready only drops when both
// output entries are full. Configuration registers are written through the
// cfg channel, which is always ready; writes to unknown indexes are dropped.
// Write configuration only while no tick is in flight.
// ----------------------------------------------------------------------------
module gear_shift_phase_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  // tick words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [4:0] demanded_gear (signed), [20:5] elapsed, [23:21] zero
  input  logic [gssp_pkg::InDataW-1:0]      s_tdata,
  // result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [4:0] gear_in_mesh (signed), [9:5] target (signed), [11:10] phase,
  // [15:12] zero
  output logic [gssp_pkg::OutDataW-1:0]     m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gssp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [gssp_pkg::CfgDataW-1:0]     cfg_data
);

  gssp_pkg::cfg_t                    cfg;
  gssp_pkg::state_t                  state;
  gssp_pkg::state_t                  state_next;
  gssp_pkg::gear_t                   demand;
  logic [gssp_pkg::TimeW-1:0]        elapsed;
  logic                              accept;
  logic [gssp_pkg::OutDataW-1:0]     result;

  assign cfg_ready = 1'b1;

  // unpack the tick word
  assign demand  = gssp_pkg::gear_t'(s_tdata[gssp_pkg::GearW-1:0]);
  assign elapsed = s_tdata[gssp_pkg::GearW +: gssp_pkg::TimeW];
  assign accept  = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_gear           <= gssp_pkg::TOP_GEAR_RST;
      cfg.upshift_time       <= gssp_pkg::UP_TIME_RST;
      cfg.downshift_time     <= gssp_pkg::DOWN_TIME_RST;
      cfg.disengage_fraction <= gssp_pkg::DIS_FRAC_RST;
      cfg.engage_fraction    <= gssp_pkg::ENG_FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gssp_pkg::REG_TOP_GEAR: begin
          cfg.top_gear <= cfg_data[gssp_pkg::TopW-1:0];
        end
        gssp_pkg::REG_UPSHIFT_TIME: begin
          cfg.upshift_time <= cfg_data[gssp_pkg::TimeW-1:0];
        end
        gssp_pkg::REG_DOWNSHIFT_TIME: begin
          cfg.downshift_time <= cfg_data[gssp_pkg::TimeW-1:0];
        end
        gssp_pkg::REG_DISENGAGE_FRAC: begin
          cfg.disengage_fraction <= cfg_data[gssp_pkg::FracW-1:0];
        end
        gssp_pkg::REG_ENGAGE_FRAC: begin
          cfg.engage_fraction <= cfg_data[gssp_pkg::FracW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // next state for this tick
  gssp_step u_step (
    .cur_state  (state),
    .cfg        (cfg),
    .demand     (demand),
    .elapsed    (elapsed),
    .next_state (state_next)
  );

  // sequencer state: neutral, engaged, timer clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result word is the state after the update
  assign result = {{(gssp_pkg::OutDataW - gssp_pkg::OutBits){1'b0}},
                   state_next.shift_phase,
                   state_next.target_gear,
                   state_next.current_gear};

  gssp_obuf #(
    .DataW (gssp_pkg::OutDataW)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .room      (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
